/* hdl/lz2_pkg.sv */
// ----------------------------------------------------------------------------
// lz2_pkg
// Shared types and constants of the level-2 LZ77 byte decompressor.
// ----------------------------------------------------------------------------
`default_nettype none
package lz2_pkg;

  localparam int HISTORY_DEPTH_DEF = 131072;
  localparam int MAX_MATCH_DEF     = 512;
  localparam int OUT_LANES_DEF     = 8;

  localparam int LEN_W       = 10;
  localparam int DIST_W      = 17;
  localparam int TOTAL_W     = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int FAR_BIAS    = 8191;

  localparam logic [1:0] CMD_LIT   = 2'd0;
  localparam logic [1:0] CMD_MATCH = 2'd1;
  localparam logic [1:0] CMD_ERR   = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DIST  = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_LONG  = 3'd4;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        byte_val;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
    logic              done;
    logic              run_end;
    logic [2:0]        status;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/lz77_level2_byte_decompressor.sv */
// ----------------------------------------------------------------------------
// lz77_level2_byte_decompressor
// Level-2 LZ77 byte-stream decompressor with a parser front and a copy back.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_byte, in_last
//  out_     output     out_valid/out_ready  out_data, out_count, out_run_end,
//                                           out_block_done, out_status
//  cfg_     input      cfg_wr_en            cfg_wr_data (output limit)
//
// The parser takes one word per cycle while the four-entry command queue
// has room. The copy engine writes a literal into the history store and
// then emits it; for a match it reads each byte from the history and then
// writes it, which keeps overlapping copies exact. The history store is
// not cleared after reset. Output stalls hold the engine; the queue keeps
// input moving.
// ----------------------------------------------------------------------------
`default_nettype none
module lz77_level2_byte_decompressor #(
  parameter int HISTORY_DEPTH = lz2_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lz2_pkg::MAX_MATCH_DEF,
  parameter int OUT_LANES     = lz2_pkg::OUT_LANES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data,
  output logic [3:0]       out_count,
  output logic             out_run_end,
  output logic             out_block_done,
  output logic [2:0]       out_status
);

  lz2_pkg::cmd_t push_cmd, head;
  logic          push, pop, full, empty;

  lz2_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .MAX_MATCH(MAX_MATCH)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .in_byte, .in_last,
    .q_full(full), .q_push(push), .q_cmd(push_cmd)
  );

  lz2_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .pop, .head, .full, .empty
  );

  lz2_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_LANES(OUT_LANES)) u_back (
    .clk, .rst_n, .head, .empty, .pop, .out_valid, .out_ready, .out_data, .out_count,
    .out_run_end, .out_block_done, .out_status
  );

endmodule
`default_nettype wire

/* hdl/lz2_front.sv */
// ----------------------------------------------------------------------------
// lz2_front
// Token parser: checks every token against the block's totals and turns
// each input word into at most one command for the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lz2_front #(
  parameter int HISTORY_DEPTH = lz2_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_MATCH     = lz2_pkg::MAX_MATCH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [23:0]          cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  input  wire logic                 q_full,
  output logic                      q_push,
  output lz2_pkg::cmd_t             q_cmd
);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_CTRL  = 3'd1;
  localparam logic [2:0] PH_LIT   = 3'd2;
  localparam logic [2:0] PH_EXT   = 3'd3;
  localparam logic [2:0] PH_OFSLO = 3'd4;
  localparam logic [2:0] PH_FARHI = 3'd5;
  localparam logic [2:0] PH_FARLO = 3'd6;

  localparam int LW = lz2_pkg::LEN_W;
  localparam int DW = lz2_pkg::DIST_W;
  localparam int TW = lz2_pkg::TOTAL_W;

  logic [2:0]    phase_r, phase_nxt;
  logic [5:0]    lit_left_r, lit_left_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [4:0]    hi5_r, hi5_nxt;
  logic [7:0]    farhi_r, farhi_nxt;
  logic [TW-1:0] prod_r, prod_nxt;
  logic          err_r, err_nxt;
  logic [23:0]   limit_r;

  logic          accept;
  logic          fail_en, new_blk, do_match;
  logic [2:0]    fail_st;
  logic          fail_re;
  logic [7:0]    ctrl;
  logic [LW-1:0] ext_sum;
  logic [DW-1:0] match_dist;
  logic [5:0]    lit_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ctrl     = (phase_r == PH_FIRST) ? {3'b000, in_byte[4:0]} : in_byte;
  assign ext_sum  = len_r + LW'(in_byte);
  assign lit_dec  = lit_left_r - 6'd1;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    len_nxt      = len_r;
    hi5_nxt      = hi5_r;
    farhi_nxt    = farhi_r;
    prod_nxt     = prod_r;
    err_nxt      = err_r;
    fail_en      = 1'b0;
    fail_st      = lz2_pkg::ST_OK;
    fail_re      = 1'b0;
    new_blk      = 1'b0;
    do_match     = 1'b0;
    match_dist   = '0;
    q_push       = 1'b0;
    q_cmd        = '0;
    if (accept) begin
      if (err_r) begin
        new_blk = in_last;
      end else begin
        case (phase_r)
          PH_FIRST, PH_CTRL: begin
            if (ctrl < 8'd32) begin
              lit_left_nxt = 6'(ctrl) + 6'd1;
              phase_nxt    = PH_LIT;
            end else begin
              hi5_nxt = ctrl[4:0];
              if (ctrl[7:5] == 3'd7) begin
                len_nxt   = LW'(9);
                phase_nxt = PH_EXT;
              end else begin
                len_nxt   = LW'(ctrl[7:5]) + LW'(2);
                phase_nxt = PH_OFSLO;
              end
            end
            if (in_last) begin
              fail_en = 1'b1;
              fail_st = lz2_pkg::ST_TRUNC;
            end
          end
          PH_LIT: begin
            if (prod_r >= limit_r) begin
              fail_en = 1'b1;
              fail_st = lz2_pkg::ST_LIMIT;
            end else begin
              prod_nxt     = prod_r + TW'(1);
              lit_left_nxt = lit_dec;
              if (lit_dec == 6'd0) phase_nxt = PH_CTRL;
              q_push           = 1'b1;
              q_cmd.kind       = lz2_pkg::CMD_LIT;
              q_cmd.byte_val   = in_byte;
              q_cmd.run_end    = 1'b1;
              q_cmd.done       = in_last;
              q_cmd.status     = (in_last && lit_dec != 6'd0) ? lz2_pkg::ST_TRUNC
                                                               : lz2_pkg::ST_OK;
              new_blk          = in_last;
            end
          end
          PH_EXT: begin
            if (ext_sum > LW'(MAX_MATCH)) begin
              fail_en = 1'b1;
              fail_st = lz2_pkg::ST_LONG;
            end else begin
              len_nxt = ext_sum;
              if (in_byte != 8'hFF) phase_nxt = PH_OFSLO;
              if (in_last) begin
                fail_en = 1'b1;
                fail_st = lz2_pkg::ST_TRUNC;
              end
            end
          end
          PH_OFSLO: begin
            if (hi5_r == 5'd31 && in_byte == 8'hFF) begin
              phase_nxt = PH_FARHI;
              if (in_last) begin
                fail_en = 1'b1;
                fail_st = lz2_pkg::ST_TRUNC;
              end
            end else begin
              do_match   = 1'b1;
              match_dist = DW'({hi5_r, in_byte}) + DW'(1);
            end
          end
          PH_FARHI: begin
            farhi_nxt = in_byte;
            phase_nxt = PH_FARLO;
            if (in_last) begin
              fail_en = 1'b1;
              fail_st = lz2_pkg::ST_TRUNC;
            end
          end
          PH_FARLO: begin
            do_match   = 1'b1;
            match_dist = DW'({farhi_r, in_byte}) + DW'(lz2_pkg::FAR_BIAS + 1);
          end
          default: begin
            new_blk = 1'b1;
          end
        endcase

        // Distance is checked before the output limit.
        if (do_match) begin
          if (match_dist > DW'(prod_r) && prod_r < TW'(1 << DW) ||
              {1'b0, match_dist} > (DW+1)'(HISTORY_DEPTH)) begin
            fail_en = 1'b1;
            fail_st = lz2_pkg::ST_DIST;
            fail_re = 1'b1;
          end else if ({1'b0, prod_r} + (TW+1)'(len_r) > {1'b0, limit_r}) begin
            fail_en = 1'b1;
            fail_st = lz2_pkg::ST_LIMIT;
            fail_re = 1'b1;
          end else begin
            prod_nxt       = prod_r + TW'(len_r);
            q_push         = 1'b1;
            q_cmd.kind     = lz2_pkg::CMD_MATCH;
            q_cmd.len      = len_r;
            q_cmd.distance = match_dist;
            q_cmd.run_end  = 1'b1;
            q_cmd.done     = in_last;
            q_cmd.status   = lz2_pkg::ST_OK;
            phase_nxt      = PH_CTRL;
            new_blk        = in_last;
          end
        end

        if (fail_en) begin
          q_push        = 1'b1;
          q_cmd         = '0;
          q_cmd.kind    = lz2_pkg::CMD_ERR;
          q_cmd.done    = 1'b1;
          q_cmd.run_end = fail_re;
          q_cmd.status  = fail_st;
          if (in_last) new_blk = 1'b1;
          else err_nxt = 1'b1;
        end
      end

      if (new_blk) begin
        phase_nxt    = PH_FIRST;
        prod_nxt     = '0;
        lit_left_nxt = '0;
        len_nxt      = '0;
        hi5_nxt      = '0;
        farhi_nxt    = '0;
        err_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      lit_left_r <= '0;
      len_r      <= '0;
      hi5_r      <= '0;
      farhi_r    <= '0;
      prod_r     <= '0;
      err_r      <= 1'b0;
      limit_r    <= 24'hFFFFFF;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      len_r      <= len_nxt;
      hi5_r      <= hi5_nxt;
      farhi_r    <= farhi_nxt;
      prod_r     <= prod_nxt;
      err_r      <= err_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
    end
  end

endmodule
`default_nettype wire

/* hdl/lz2_queue.sv */
// ----------------------------------------------------------------------------
// lz2_queue
// Short command FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lz2_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lz2_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output lz2_pkg::cmd_t      head,
  output logic               full,
  output logic               empty
);

  localparam int QD = lz2_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);

  lz2_pkg::cmd_t  mem_r [QD];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    count_r;

  assign full  = (count_r == (PW+1)'(QD));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

/* hdl/lz2_back.sv */
// ----------------------------------------------------------------------------
// lz2_back
// Copy engine: writes literals into the history store, expands matches a
// byte at a time and packs the output words.
// ----------------------------------------------------------------------------
`default_nettype none
module lz2_back #(
  parameter int HISTORY_DEPTH = lz2_pkg::HISTORY_DEPTH_DEF,
  parameter int OUT_LANES     = lz2_pkg::OUT_LANES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lz2_pkg::cmd_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [63:0]        out_data,
  output logic [3:0]         out_count,
  output logic               out_run_end,
  output logic               out_block_done,
  output logic [2:0]         out_status
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = lz2_pkg::LEN_W;
  localparam int XW = lz2_pkg::DIST_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [7:0]    hist [HISTORY_DEPTH];
  logic [7:0]    rd_data_r;

  logic [1:0]    state_r, state_nxt;
  lz2_pkg::cmd_t cmd_r, cmd_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [AW-1:0] wp_r, wp_nxt, wp_inc;
  logic [63:0]   word_r, word_nxt;
  logic [3:0]    cnt_r, cnt_nxt;

  logic          ov_r, ov_nxt;
  logic [63:0]   od_r, od_nxt;
  logic [3:0]    oc_r, oc_nxt;
  logic          ore_r, ore_nxt, odn_r, odn_nxt;
  logic [2:0]    ost_r, ost_nxt;

  logic          wr_en, rd_en, out_free, final_word;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic [XW-1:0] wp_x, d_x;

  assign wp_x     = XW'(wp_r);
  assign d_x      = XW'(cmd_r.distance);
  assign rd_addr  = (wp_x >= d_x) ? AW'(wp_x - d_x) : AW'(wp_x + XW'(HISTORY_DEPTH) - d_x);
  assign wp_inc   = (wp_x + XW'(1) >= XW'(HISTORY_DEPTH)) ? '0 : wp_r + AW'(1);
  assign out_free = !ov_r || out_ready;
  assign final_word = (cmd_r.kind != lz2_pkg::CMD_MATCH) || (left_r == '0);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    left_nxt  = left_r;
    wp_nxt    = wp_r;
    word_nxt  = word_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    oc_nxt    = oc_r;
    ore_nxt   = ore_r;
    odn_nxt   = odn_r;
    ost_nxt   = ost_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = wp_r;
    wr_data   = rd_data_r;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          cmd_nxt  = head;
          left_nxt = head.len;
          word_nxt = '0;
          cnt_nxt  = '0;
          case (head.kind)
            lz2_pkg::CMD_LIT: begin
              wr_en     = 1'b1;
              wr_data   = head.byte_val;
              wp_nxt    = wp_inc;
              word_nxt  = 64'(head.byte_val);
              cnt_nxt   = 4'd1;
              state_nxt = S_EMIT;
            end
            lz2_pkg::CMD_MATCH: state_nxt = S_RD;
            default:            state_nxt = S_EMIT;
          endcase
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        // The byte just read may have been written one byte earlier, which
        // is how overlapping copies repeat recent output.
        wr_en    = 1'b1;
        wp_nxt   = wp_inc;
        word_nxt = word_r | (64'(rd_data_r) << {cnt_r, 3'b000});
        cnt_nxt  = cnt_r + 4'd1;
        left_nxt = left_r - LW'(1);
        if (cnt_r + 4'd1 == 4'(OUT_LANES) || left_r == LW'(1)) state_nxt = S_EMIT;
        else state_nxt = S_RD;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt  = 1'b1;
          od_nxt  = word_r;
          oc_nxt  = cnt_r;
          ore_nxt = final_word && cmd_r.run_end;
          odn_nxt = final_word && cmd_r.done;
          ost_nxt = final_word ? cmd_r.status : lz2_pkg::ST_OK;
          word_nxt = '0;
          cnt_nxt  = '0;
          if (!final_word) begin
            state_nxt = S_RD;
          end else begin
            if (cmd_r.done) wp_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    left_r <= left_nxt;
    word_r <= word_nxt;
    cnt_r  <= cnt_nxt;
    od_r   <= od_nxt;
    oc_r   <= oc_nxt;
    ore_r  <= ore_nxt;
    odn_r  <= odn_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_valid      = ov_r;
  assign out_data       = od_r;
  assign out_count      = oc_r;
  assign out_run_end    = ore_r;
  assign out_block_done = odn_r;
  assign out_status     = ost_r;

endmodule
`default_nettype wire

/* hdl/lz2_checker.sv */
// ----------------------------------------------------------------------------
// lz2_checker
// Port-level checks of the decompressor's result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module lz2_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_data,
  input wire logic [3:0]  out_count,
  input wire logic        out_run_end,
  input wire logic        out_block_done,
  input wire logic [2:0]  out_status
);

  // A word that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_count))
    else $error("stalled output word changed");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= 4'd8)
    else $error("output count above eight");

  // Any error status closes the block.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lz2_pkg::ST_OK |-> out_block_done)
    else $error("error status without block end");

  // An empty word only reports an error.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == 4'd0 |-> out_block_done && out_status != lz2_pkg::ST_OK)
    else $error("empty word without error");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_done && out_count != 4'd0 |-> out_run_end)
    else $error("block ended inside a run");

endmodule

bind lz77_level2_byte_decompressor lz2_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data, .out_count, .out_run_end,
  .out_block_done, .out_status
);
`default_nettype wire

/* test/lz77_level2_byte_decompressor_tb.sv */
// ----------------------------------------------------------------------------
// lz77_level2_byte_decompressor_tb
// Drives compressed byte streams (directed token corner cases, then random
// well-formed blocks with some broken ones) under random idling on both sides.
// An in-bench decoder predicts every output word, and a scoreboard checks
// each field in order. The output limit is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module lz77_level2_byte_decompressor_tb;

  localparam int HIST = lz2_pkg::HISTORY_DEPTH_DEF;
  localparam int MAXM = lz2_pkg::MAX_MATCH_DEF;
  localparam int LANES = lz2_pkg::OUT_LANES_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 1500;

  typedef enum logic [2:0] {
    P_FIRST, P_CTRL, P_LIT, P_EXT, P_OFSLO, P_FARHI, P_FARLO
  } parse_e;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        run_end;
    logic        done;
    logic [2:0]  status;
  } word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } token_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [23:0] cfg_wr_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_last = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        out_run_end;
  logic        out_block_done;
  logic [2:0]  out_status;

  lz77_level2_byte_decompressor dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .out_count(out_count), .out_run_end(out_run_end),
    .out_block_done(out_block_done), .out_status(out_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Decoder state.
  logic [7:0]  hist [0:HIST-1];
  logic [16:0] wr_ptr;
  int          total;
  parse_e      phase;
  int          lit_left;
  int          mlen;
  int          mdist;
  bit          draining;
  int          out_limit = 24'hFFFFFF;

  token_t      byte_queue[$];
  word_t       expected_words[$];
  word_t       step_words[$];
  int          errors = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  bit          in_idle_on = 1;
  bit          out_idle_on = 1;

  task automatic start_block();
    phase = P_FIRST;
    total = 0;
    wr_ptr = '0;
    lit_left = 0;
    mlen = 0;
    mdist = 0;
    draining = 0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    total = (total + 1) & 24'hFFFFFF;
  endtask

  task automatic fail_word(input logic [2:0] st, input logic last);
    word_t w;
    w = '0;
    w.done = 1;
    w.status = st;
    step_words.push_back(w);
    if (last) start_block();
    else draining = 1;
  endtask

  task automatic copy_match(input int distance, input logic last);
    word_t w;
    int left;
    logic [16:0] rd;
    if (distance == 0 || distance > total || distance > HIST) begin
      fail_word(lz2_pkg::ST_DIST, last);
      return;
    end
    if (total + mlen > out_limit) begin
      fail_word(lz2_pkg::ST_LIMIT, last);
      return;
    end
    left = mlen;
    while (left > 0) begin
      w = '0;
      while (w.count < LANES && left > 0) begin
        rd = wr_ptr - distance[16:0];
        w.data[8*w.count +: 8] = hist[rd];
        store_byte(hist[rd]);
        w.count++;
        left--;
      end
      step_words.push_back(w);
    end
    if (last) begin
      step_words[$].done = 1;
      start_block();
    end else begin
      phase = P_CTRL;
    end
  endtask

  // Works out the output words that one accepted compressed byte causes.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    word_t w;
    int ctrl;
    bit mark_end;
    step_words = {};
    mark_end = 1;
    if (draining) begin
      if (last) start_block();
      return;
    end
    case (phase)
      P_FIRST, P_CTRL: begin
        ctrl = (phase == P_FIRST) ? (b & 31) : b;
        if (ctrl < 32) begin
          lit_left = ctrl + 1;
          phase = P_LIT;
        end else begin
          mdist = (ctrl & 31) << 8;
          if ((ctrl >> 5) == 7) begin
            mlen = 9;
            phase = P_EXT;
          end else begin
            mlen = (ctrl >> 5) + 2;
            phase = P_OFSLO;
          end
        end
        mark_end = 0;
        if (last) fail_word(lz2_pkg::ST_TRUNC, 1);
      end
      P_LIT: begin
        if (total >= out_limit) begin
          mark_end = 0;
          fail_word(lz2_pkg::ST_LIMIT, last);
        end else begin
          store_byte(b);
          lit_left = (lit_left - 1) & 63;
          if (lit_left == 0) phase = P_CTRL;
          w = '0;
          w.data[7:0] = b;
          w.count = 1;
          if (last) begin
            w.done = 1;
            w.status = (lit_left == 0) ? lz2_pkg::ST_OK : lz2_pkg::ST_TRUNC;
          end
          step_words.push_back(w);
          if (last) start_block();
        end
      end
      P_EXT: begin
        mark_end = 0;
        mlen += b;
        if (mlen > MAXM) fail_word(lz2_pkg::ST_LONG, last);
        else begin
          if (b != 8'hFF) phase = P_OFSLO;
          if (last) fail_word(lz2_pkg::ST_TRUNC, 1);
        end
      end
      P_OFSLO: begin
        if ((mdist >> 8) == 31 && b == 8'hFF) begin
          mark_end = 0;
          phase = P_FARHI;
          if (last) fail_word(lz2_pkg::ST_TRUNC, 1);
        end else begin
          copy_match(mdist + b + 1, last);
        end
      end
      P_FARHI: begin
        mark_end = 0;
        mdist = b;
        phase = P_FARLO;
        if (last) fail_word(lz2_pkg::ST_TRUNC, 1);
      end
      default: copy_match((((mdist & 255) << 8) | b) + lz2_pkg::FAR_BIAS + 1, last);
    endcase
    if (mark_end && step_words.size() > 0) step_words[$].run_end = 1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  // Input driver: one word per handshake, random gaps between words.
  always @(posedge clk) begin
    token_t t;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (byte_queue.size() > 0) begin
          t = byte_queue.pop_front();
          in_byte <= t.b;
          in_last <= t.last;
          in_valid <= 1;
          if ($urandom_range(0, 31) == 0) in_idle_on = ~in_idle_on;
          in_gap = in_idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Output monitor and scoreboard.
  always @(posedge clk) begin
    word_t e;
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("output word with nothing expected: data=%h count=%0d", out_data, out_count);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_data !== e.data) begin
            $error("out_data: expected %h, got %h", e.data, out_data);
            errors++;
          end
          if (out_count !== e.count) begin
            $error("out_count: expected %0d, got %0d", e.count, out_count);
            errors++;
          end
          if (out_run_end !== e.run_end) begin
            $error("out_run_end: expected %0d, got %0d", e.run_end, out_run_end);
            errors++;
          end
          if (out_block_done !== e.done) begin
            $error("out_block_done: expected %0d, got %0d", e.done, out_block_done);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("out_status: expected %0d, got %0d", e.status, out_status);
            errors++;
          end
        end
        if ($urandom_range(0, 31) == 0) out_idle_on = ~out_idle_on;
        out_stall = out_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push(input logic [7:0] b, input logic last = 0);
    byte_queue.push_back({b, last});
  endtask

  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [23:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    out_limit = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  // One random block. Mostly well-formed; some end early or carry bad distances.
  task automatic random_block(output int n);
    token_t blk[$];
    int prod, len, d, code, ext, k;
    blk = {};
    len = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 7);
    blk.push_back({8'($urandom_range(0, 7) << 5 | len), 1'b0});
    for (int i = 0; i <= len; i++) blk.push_back({8'($urandom), 1'b0});
    prod = len + 1;
    k = $urandom_range(1, 6);
    for (int t = 0; t < k; t++) begin
      if ($urandom_range(0, 1)) begin
        len = $urandom_range(0, 7);
        blk.push_back({8'(len), 1'b0});
        for (int i = 0; i <= len; i++) blk.push_back({8'($urandom), 1'b0});
        prod += len + 1;
      end else begin
        code = $urandom_range(1, 7);
        d = $urandom_range(1, (prod < 8191) ? prod : 8191);
        if ($urandom_range(0, 9) == 0) d = prod + $urandom_range(1, 4);
        if (d > 8191) d = 8191;
        blk.push_back({8'(code << 5 | ((d - 1) >> 8)), 1'b0});
        len = code + 2;
        if (code == 7) begin
          if ($urandom_range(0, 7) == 0) begin
            blk.push_back({8'hFF, 1'b0});
            len += 255;
          end
          ext = $urandom_range(0, 40);
          blk.push_back({8'(ext), 1'b0});
          len += ext;
        end
        blk.push_back({8'((d - 1) & 255), 1'b0});
        prod += len;
      end
    end
    if ($urandom_range(0, 7) == 0) blk[$urandom_range(0, blk.size() - 1)].last = 1;
    blk[$].last = 1;
    foreach (blk[i]) byte_queue.push_back(blk[i]);
    n = blk.size();
  endtask

  task automatic random_phase(input int target);
    int n, sent;
    sent = 0;
    while (sent < target) begin
      random_block(n);
      sent += n;
    end
  endtask

  initial begin
    start_block();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Overlapping copies, then a distance reaching before the start.
    push(8'hE2); push(8'h00); push(8'hFF); push(8'h5A);
    push(8'h20); push(8'h00);
    push(8'hE0); push(8'h00); push(8'h02);
    push(8'h40); push(8'h10); push(8'h11, 1);
    // Truncated control, truncated literal run.
    push(8'h00, 1);
    push(8'h01); push(8'h77, 1);
    // Extension chain past the longest match, then drain.
    push(8'h00); push(8'h33); push(8'hE0); push(8'hFF); push(8'hFF); push(8'h00, 1);
    // Truncation on extension byte and on the far-offset marker.
    push(8'h00); push(8'h01); push(8'hE0); push(8'h05, 1);
    push(8'h00); push(8'h01); push(8'h3F); push(8'hFF, 1);
    // Far offset: build over 8192 bytes with maximum length matches first.
    push(8'h00); push(8'hAB);
    for (int i = 0; i < 17; i++) begin
      push(8'hE0); push(8'hFF); push(8'hF8); push(8'h00);
    end
    push(8'h3F); push(8'hFF); push(8'h00); push(8'h05, 1);
    random_phase(10);
    wait_idle();

    // A limit of one byte: literal over the limit, and a match over it.
    write_limit(24'd1);
    push(8'h01); push(8'hAA); push(8'hBB); push(8'h00, 1);
    push(8'h00); push(8'h12); push(8'h20); push(8'h00, 1);
    wait_idle();

    write_limit(24'd40);
    random_phase(8);
    wait_idle();

    write_limit(24'hFFFFFF);
    random_phase(15);
    wait_idle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lz2_pkg.sv
hdl/lz2_front.sv
hdl/lz2_queue.sv
hdl/lz2_back.sv
hdl/lz77_level2_byte_decompressor.sv
hdl/lz2_checker.sv
test/lz77_level2_byte_decompressor_tb.sv
